@@ src/ibal_pkg.sv @@
// Shared types, constants and helpers for the inode block allocator.
// No dependencies; ibal_slots and inode_block_allocator refer to this package.
`timescale 1ns / 1ps
`default_nettype none
package ibal_pkg;

  localparam int BLOCKS      = 1024;
  localparam int SLOTS       = 10;
  localparam int BLOCK_BYTES = 512;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int BLK_AW      = $clog2(BLOCKS);
  localparam int CNT_W       = BLK_AW + 1;
  localparam int SLOT_W      = 4;
  localparam int FB_W        = 20;
  localparam int ENTRY_W     = 1 + SLOT_W;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_FREE   = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_LOOKUP = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_TABLE_FUL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] name_low;
    logic [23:0] name_high;
    logic [19:0] size_bytes;
    logic [9:0]  block_index;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [3:0]      slot;
    logic [10:0]     block_count;
    logic [FB_W-1:0] free_bytes;
    logic            block_used;
    logic [3:0]      block_owner;
  } rsp_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [SLOT_W-1:0] idx;
    logic [63:0]       name_low;
    logic [23:0]       name_high;
  } slot_cmd_t;

  typedef struct packed {
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              match_found;
    logic [SLOT_W-1:0] match_idx;
  } slot_stat_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_COUNT, S_ALLOC, S_DELETE, S_READ, S_DONE
  } state_t;

  // Zero every name byte after the first zero byte.
  function automatic logic [87:0] norm_name(input logic [87:0] nm);
    logic [87:0] r;
    logic        ended;
    begin
      r = nm;
      ended = 1'b0;
      for (int i = 0; i < 11; i++) begin
        if (ended) begin
          r[8*i +: 8] = 8'd0;
        end else if (nm[8*i +: 8] == 8'd0) begin
          ended = 1'b1;
        end
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ src/ibal_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ibal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/ibal_slots.sv @@
// File slot table: valid bits, stored names, lowest free slot and name match.
// Depends on ibal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ibal_slots (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ibal_pkg::slot_cmd_t cmd,
  input  wire logic [63:0]        key_low,
  input  wire logic [23:0]        key_high,
  output ibal_pkg::slot_stat_t    stat
);
  logic [ibal_pkg::SLOTS-1:0] valid;
  logic [63:0] name_low  [ibal_pkg::SLOTS];
  logic [23:0] name_high [ibal_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.set) begin
      valid[cmd.idx] <= 1'b1;
    end else if (cmd.clr) begin
      valid[cmd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      name_low[cmd.idx]  <= cmd.name_low;
      name_high[cmd.idx] <= cmd.name_high;
    end
  end

  // Priority searches from the highest slot down so the lowest one wins.
  always_comb begin
    stat = '0;
    for (int s = ibal_pkg::SLOTS - 1; s >= 0; s--) begin
      if (!valid[s]) begin
        stat.free_found = 1'b1;
        stat.free_idx   = ibal_pkg::SLOT_W'(s);
      end
      if (valid[s] && name_low[s] == key_low && name_high[s] == key_high) begin
        stat.match_found = 1'b1;
        stat.match_idx   = ibal_pkg::SLOT_W'(s);
      end
    end
  end
endmodule
`default_nettype wire

@@ src/inode_block_allocator.sv @@
// Top level of the inode block allocator: sequencer, block map RAM and slot table.
// Depends on ibal_pkg, ibal_ram and ibal_slots.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps a used bit and an owning slot for each of 1024 disk blocks in
// one RAM, and a ten-entry file table in registers. One item is worked on at a
// time. After reset the block map is cleared by a pass over every block, during
// which no item is taken; configuration writes are always accepted. Free-space
// queries scan the map once, one block per cycle. Create scans once to count
// free blocks and a second time to mark them; Delete scans the whole map. Scans
// go through the block map RAM, with its single read and write port. A finished
// result sits in an output register, so the next item is accepted while it
// waits to be taken.
module inode_block_allocator (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire ibal_pkg::req_t  req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output ibal_pkg::rsp_t       rsp,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [10:0]     cfg_data
);
  localparam int CW = ibal_pkg::CNT_W;
  localparam int AW = ibal_pkg::BLK_AW;
  localparam int SW = ibal_pkg::SLOT_W;

  ibal_pkg::state_t state, state_next;

  logic [10:0]    total_blocks;
  logic [CW-1:0]  tb_eff;
  logic [CW-1:0]  addr, addr_next;
  logic [CW-1:0]  limit, limit_next;
  logic           pend;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  cnt, cnt_next;
  logic [SW-1:0]  cur_slot, cur_slot_next;
  logic [1:0]     st, st_next;
  logic           bused, bused_next;
  logic [3:0]     bown, bown_next;
  logic [2:0]     act;
  logic [63:0]    nm_low;
  logic [23:0]    nm_high;
  logic [CW-1:0]  need;
  logic [9:0]     bidx;
  logic [87:0]    nm_norm;

  logic                   issue;
  logic                   scan_end;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [ibal_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic                   blk_busy;
  logic [SW-1:0]          blk_owner;
  logic                   accept, load_out;
  ibal_pkg::slot_cmd_t    scmd;
  ibal_pkg::slot_stat_t   sstat;
  ibal_pkg::rsp_t         res;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != ibal_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign load_out  = (state == ibal_pkg::S_DONE) && (!rsp_valid || !rsp_stall);
  assign nm_norm   = ibal_pkg::norm_name({req.name_high, req.name_low});
  assign tb_eff    = (total_blocks > CW'(ibal_pkg::BLOCKS)) ? CW'(ibal_pkg::BLOCKS)
                                                            : total_blocks;
  assign blk_busy  = ram_rdata[ibal_pkg::ENTRY_W-1];
  assign blk_owner = ram_rdata[SW-1:0];

  // A read is issued each scan cycle until the scan limit; its data returns in the next cycle.
  assign issue = ((state == ibal_pkg::S_COUNT) || (state == ibal_pkg::S_ALLOC) ||
                  (state == ibal_pkg::S_DELETE)) && (addr < limit);
  assign scan_end = !issue && !pend;

  ibal_ram #(.WIDTH(ibal_pkg::ENTRY_W), .DEPTH(ibal_pkg::BLOCKS)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  ibal_slots u_slots (
    .clk(clk), .rst(rst), .cmd(scmd), .key_low(nm_low), .key_high(nm_high), .stat(sstat)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ibal_pkg::S_CLEAR: begin
        if (addr == CW'(ibal_pkg::BLOCKS - 1)) state_next = ibal_pkg::S_IDLE;
      end
      ibal_pkg::S_IDLE: begin
        if (accept) state_next = ibal_pkg::S_DISPATCH;
      end
      ibal_pkg::S_DISPATCH: begin
        case (act)
          ibal_pkg::ACT_CREATE: state_next = sstat.free_found ? ibal_pkg::S_COUNT
                                                              : ibal_pkg::S_DONE;
          ibal_pkg::ACT_DELETE: state_next = sstat.match_found ? ibal_pkg::S_DELETE
                                                               : ibal_pkg::S_DONE;
          ibal_pkg::ACT_FREE:   state_next = ibal_pkg::S_COUNT;
          ibal_pkg::ACT_READ:   state_next = ibal_pkg::S_READ;
          default:              state_next = ibal_pkg::S_DONE;
        endcase
      end
      ibal_pkg::S_COUNT: begin
        if (scan_end) begin
          if (act == ibal_pkg::ACT_CREATE && need <= cnt) state_next = ibal_pkg::S_ALLOC;
          else state_next = ibal_pkg::S_DONE;
        end
      end
      ibal_pkg::S_ALLOC: begin
        if (cnt == need || scan_end) state_next = ibal_pkg::S_DONE;
      end
      ibal_pkg::S_DELETE: begin
        if (scan_end) state_next = ibal_pkg::S_DONE;
      end
      ibal_pkg::S_READ: state_next = ibal_pkg::S_DONE;
      ibal_pkg::S_DONE: begin
        if (load_out) state_next = ibal_pkg::S_IDLE;
      end
      default: state_next = ibal_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory port and slot table control.
  always_comb begin
    addr_next     = issue ? addr + CW'(1) : addr;
    limit_next    = limit;
    cnt_next      = cnt;
    cur_slot_next = cur_slot;
    st_next       = st;
    bused_next    = bused;
    bown_next     = bown;
    ram_we        = 1'b0;
    ram_waddr     = rd_addr;
    ram_wdata     = '0;
    ram_raddr     = addr[AW-1:0];
    scmd          = '0;
    scmd.name_low  = nm_low;
    scmd.name_high = nm_high;
    case (state)
      ibal_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr[AW-1:0];
        addr_next = addr + CW'(1);
      end
      ibal_pkg::S_DISPATCH: begin
        addr_next     = '0;
        cnt_next      = '0;
        cur_slot_next = '0;
        st_next       = ibal_pkg::ST_OK;
        bused_next    = 1'b0;
        bown_next     = '0;
        limit_next    = tb_eff;
        ram_raddr     = bidx[AW-1:0];
        case (act)
          ibal_pkg::ACT_CREATE: begin
            if (sstat.free_found) begin
              scmd.set      = 1'b1;
              scmd.idx      = sstat.free_idx;
              cur_slot_next = sstat.free_idx;
            end else begin
              st_next = ibal_pkg::ST_TABLE_FUL;
            end
          end
          ibal_pkg::ACT_DELETE: begin
            limit_next = CW'(ibal_pkg::BLOCKS);
            if (sstat.match_found) cur_slot_next = sstat.match_idx;
            else st_next = ibal_pkg::ST_NOT_FOUND;
          end
          ibal_pkg::ACT_LOOKUP: begin
            if (sstat.match_found) cur_slot_next = sstat.match_idx;
            else st_next = ibal_pkg::ST_NOT_FOUND;
          end
          default: ;
        endcase
      end
      ibal_pkg::S_COUNT: begin
        if (pend && !blk_busy) cnt_next = cnt + CW'(1);
        if (scan_end) begin
          addr_next = '0;
          if (act == ibal_pkg::ACT_CREATE) begin
            if (need <= cnt) begin
              cnt_next = '0;
            end else begin
              cnt_next = '0;
              st_next  = ibal_pkg::ST_NO_SPACE;
            end
          end
        end
      end
      ibal_pkg::S_ALLOC: begin
        if (pend && !blk_busy && cnt < need) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, cur_slot};
          cnt_next  = cnt + CW'(1);
        end
      end
      ibal_pkg::S_DELETE: begin
        if (pend && blk_busy && blk_owner == cur_slot) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, blk_owner};
          cnt_next  = cnt + CW'(1);
        end
        if (scan_end) begin
          scmd.clr = 1'b1;
          scmd.idx = cur_slot;
        end
      end
      ibal_pkg::S_READ: begin
        if (CW'(bidx) < tb_eff && blk_busy) begin
          bused_next = 1'b1;
          bown_next  = blk_owner;
        end
      end
      default: ;
    endcase
  end

  // Result assembled from the working registers; unused fields stay zero.
  always_comb begin
    res = '0;
    case (act)
      ibal_pkg::ACT_CREATE, ibal_pkg::ACT_DELETE: begin
        res.status      = st;
        res.slot        = cur_slot;
        res.block_count = cnt;
      end
      ibal_pkg::ACT_FREE: res.free_bytes = ibal_pkg::FB_W'(cnt) << ibal_pkg::BLOCK_SHIFT;
      ibal_pkg::ACT_READ: begin
        res.block_used  = bused;
        res.block_owner = bown;
      end
      ibal_pkg::ACT_LOOKUP: begin
        res.status = st;
        res.slot   = cur_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ibal_pkg::S_CLEAR;
      addr         <= '0;
      pend         <= 1'b0;
      rsp_valid    <= 1'b0;
      total_blocks <= 11'(ibal_pkg::BLOCKS);
    end else begin
      state <= state_next;
      addr  <= addr_next;
      pend  <= issue;
      if (load_out) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      if (cfg_valid && cfg_ready) total_blocks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr  <= addr[AW-1:0];
    limit    <= limit_next;
    cnt      <= cnt_next;
    cur_slot <= cur_slot_next;
    st       <= st_next;
    bused    <= bused_next;
    bown     <= bown_next;
    if (load_out) rsp <= res;
    if (accept) begin
      act     <= req.action;
      nm_low  <= nm_norm[63:0];
      nm_high <= nm_norm[87:64];
      need    <= CW'(req.size_bytes >> ibal_pkg::BLOCK_SHIFT);
      bidx    <= req.block_index;
    end
  end
endmodule
`default_nettype wire
